FILE: rtl/core/lua_source_minify_filter_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Lua source minify filter
// Concurrent checks on clk, disabled while rst_n is low; empty under SYNTH.
// ----------------------------------------------------------------------------
`ifndef LUA_SOURCE_MINIFY_FILTER_DEFINES_SVH
`define LUA_SOURCE_MINIFY_FILTER_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication
`define LSMF_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lsmf: same-cycle check failed");

// Next-cycle implication
`define LSMF_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lsmf: next-cycle check failed");

`else

`define LSMF_ASSERT_IMPL(name, ante, cons)
`define LSMF_ASSERT_NEXT(name, ante, cons)

`endif

`endif

FILE: rtl/core/lsmf_pkg.sv
// ----------------------------------------------------------------------------
// Lua source minify filter package
// Transaction types, scanner modes, error codes and character constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lsmf_pkg;

    // Deepest long-bracket level accepted by default
    localparam int MAX_LEVEL_DEF = 15;

    // Characters of interest
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_LBR    = 8'h5B;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_RBR    = 8'h5D;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_COMMENT = 2'd1,
        ERR_STRING  = 2'd2,
        ERR_LEVEL   = 2'd3
    } err_kind_t;

    typedef enum logic [3:0] {
        M_NORMAL       = 4'd0,
        M_AFT_COMMENT  = 4'd1,
        M_AFT_QUOTE    = 4'd2,
        M_AFT_LONG     = 4'd3,
        M_PEND_DASH    = 4'd4,
        M_PEND_BRACKET = 4'd5,
        M_CMT_OPEN     = 4'd6,
        M_LINE_CMT     = 4'd7,
        M_LCMT_OPEN    = 4'd8,
        M_LCMT_BODY    = 4'd9,
        M_QSTR         = 4'd10,
        M_QSTR_ESC     = 4'd11,
        M_LSTR_OPEN    = 4'd12,
        M_LSTR_BODY    = 4'd13,
        M_DRAIN        = 4'd14
    } scan_mode_t;

    // Which checks a fresh token goes through
    typedef enum logic [1:0] {
        LV_FULL    = 2'd0,
        LV_QUOTE   = 2'd1,
        LV_BRACKET = 2'd2,
        LV_PLAIN   = 2'd3
    } entry_lvl_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       stream_end;
        err_kind_t  error_kind;
    } out_item_t;

endpackage

`default_nettype wire

FILE: rtl/core/lua_source_minify_filter.sv
// ----------------------------------------------------------------------------
// Lua source minify filter
// Single-pass byte scanner that strips comments and indentation from Lua text.
// ----------------------------------------------------------------------------
// An input byte is registered, then scanned combinationally against the
// scanner state, giving zero to three output transactions that are loaded into
// a three-entry result buffer and presented one per cycle while mini_stall is
// low. A byte that yields at most one result passes at one byte per cycle
// while the output is not stalled; a byte that yields k results (a held dash
// or bracket released together with the next byte, or the flush at the end of
// the script) keeps the result buffer busy, and the input stalls until the
// last of its results is being taken. After an error the filter swallows bytes
// up to and including the one flagged in_last, then starts afresh.
`timescale 1ns / 1ps
`default_nettype none

`include "lua_source_minify_filter_defines.svh"

module lua_source_minify_filter #(
    parameter int MAX_LEVEL = lsmf_pkg::MAX_LEVEL_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               script_valid,
    output logic                    script_stall,
    input  wire lsmf_pkg::in_item_t script_item,
    output logic                    mini_valid,
    input  wire logic               mini_stall,
    output lsmf_pkg::out_item_t     mini_item
);

    import lsmf_pkg::*;

    localparam int LVL_W = $clog2(MAX_LEVEL + 1);
    localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(MAX_LEVEL);

    typedef struct packed {
        scan_mode_t       mode;
        logic [LVL_W-1:0] level;
        logic [LVL_W-1:0] eq_seen;
        logic             cand;
        logic [7:0]       quote;
        logic [7:0]       held;
        logic             held_v;
        logic             line_st;
    } scan_state_t;

    typedef struct packed {
        scan_state_t     s;
        logic [1:0]      n;
        out_item_t [2:0] r;
    } step_t;

    localparam scan_state_t STATE_RST = '{
        mode: M_NORMAL, level: '0, eq_seen: '0, cand: 1'b0,
        quote: '0, held: '0, held_v: 1'b0, line_st: 1'b1
    };

    // ------------------------------------------------------------------
    // Scanner helpers
    // ------------------------------------------------------------------
    function automatic step_t f_push(step_t t, logic [7:0] b, logic e, err_kind_t k);
        step_t u;
        u = t;
        u.r[t.n].out_byte   = b;
        u.r[t.n].run_last   = 1'b0;
        u.r[t.n].stream_end = e;
        u.r[t.n].error_kind = k;
        u.n = t.n + 2'd1;
        return u;
    endfunction

    // Release the held byte and hold the new one
    function automatic step_t f_emit(step_t t, logic [7:0] b);
        step_t u;
        u = t;
        if (t.s.held_v)
        begin
            u = f_push(u, t.s.held, 1'b0, ERR_NONE);
        end
        u.s.held   = b;
        u.s.held_v = 1'b1;
        return u;
    endfunction

    function automatic step_t f_raise(step_t t, err_kind_t k);
        step_t u;
        u = t;
        u.s.held_v = 1'b0;
        u = f_push(u, 8'h00, 1'b1, k);
        u.s.mode = M_DRAIN;
        return u;
    endfunction

    function automatic step_t f_enter(step_t t, entry_lvl_t lv, logic [7:0] b);
        step_t u;
        u = t;
        if (lv == LV_FULL && b == CH_DASH)
        begin
            u.s.mode = M_PEND_DASH;
        end
        else if ((lv == LV_FULL || lv == LV_QUOTE) && (b == CH_SQUOTE || b == CH_DQUOTE))
        begin
            u = f_emit(u, b);
            u.s.quote = b;
            u.s.mode  = M_QSTR;
        end
        else if (lv != LV_PLAIN && b == CH_LBR)
        begin
            u.s.mode = M_PEND_BRACKET;
        end
        else
        begin
            u.s.mode = M_NORMAL;
            if (b != CH_CR)
            begin
                u = f_emit(u, b);
                if (b == CH_LF)
                begin
                    u.s.line_st = 1'b1;
                end
            end
        end
        return u;
    endfunction

    // Closing bracket sequence completes on this byte
    function automatic logic f_close_done(scan_state_t s, logic [7:0] b);
        return s.cand && b == CH_RBR && s.eq_seen == s.level;
    endfunction

    function automatic scan_state_t f_close_upd(scan_state_t s, logic [7:0] b);
        scan_state_t u;
        u = s;
        if (s.cand)
        begin
            if (b == CH_EQ && s.eq_seen < s.level)
            begin
                u.eq_seen = s.eq_seen + LVL_W'(1);
                return u;
            end
            u.cand = 1'b0;
            if (b == CH_RBR && s.eq_seen == s.level)
            begin
                return u;
            end
        end
        if (b == CH_RBR)
        begin
            u.cand    = 1'b1;
            u.eq_seen = '0;
        end
        return u;
    endfunction

    function automatic step_t f_line_cmt(step_t t, logic [7:0] b);
        step_t u;
        u = t;
        if (b == CH_LF)
        begin
            u = f_emit(u, CH_LF);
            u.s.line_st = 1'b1;
            u.s.mode    = M_NORMAL;
        end
        else
        begin
            u.s.mode = M_LINE_CMT;
        end
        return u;
    endfunction

    function automatic step_t f_quoted(step_t t, logic [7:0] b);
        step_t u;
        u = f_emit(t, b);
        if (b == t.s.quote)
        begin
            u.s.mode = M_AFT_QUOTE;
        end
        else if (b == CH_BSLASH)
        begin
            u.s.mode = M_QSTR_ESC;
        end
        else
        begin
            u.s.mode = M_QSTR;
        end
        return u;
    endfunction

    function automatic step_t f_lstr_open(step_t t, logic [7:0] b);
        step_t u;
        u = t;
        if (b == CH_EQ)
        begin
            if (t.s.level >= LVL_MAX)
            begin
                u = f_raise(u, ERR_LEVEL);
            end
            else
            begin
                u.s.level = t.s.level + LVL_W'(1);
                u = f_emit(u, b);
            end
        end
        else if (b == CH_LBR)
        begin
            u = f_emit(u, b);
            u.s.cand    = 1'b0;
            u.s.eq_seen = '0;
            u.s.mode    = M_LSTR_BODY;
        end
        else
        begin
            u = f_raise(u, ERR_STRING);
        end
        return u;
    endfunction

    // One full scan step for one input byte
    function automatic step_t f_step(scan_state_t s0, logic [7:0] b, logic last);
        step_t t;
        logic  done;
        t.s  = s0;
        t.n  = 2'd0;
        t.r  = '0;
        done = 1'b0;
        case (s0.mode)
            M_NORMAL:
            begin
                if (!(s0.line_st && (b == CH_SPACE || b == CH_TAB || b == CH_CR)))
                begin
                    t.s.line_st = 1'b0;
                    t = f_enter(t, LV_FULL, b);
                end
            end
            M_AFT_COMMENT:  t = f_enter(t, LV_QUOTE, b);
            M_AFT_QUOTE:    t = f_enter(t, LV_BRACKET, b);
            M_AFT_LONG:     t = f_enter(t, LV_PLAIN, b);
            M_PEND_DASH:
            begin
                if (b == CH_DASH)
                begin
                    t.s.mode = M_CMT_OPEN;
                end
                else
                begin
                    t = f_emit(t, CH_DASH);
                    t = f_enter(t, LV_FULL, b);
                end
            end
            M_PEND_BRACKET:
            begin
                t = f_emit(t, CH_LBR);
                if (b == CH_EQ || b == CH_LBR)
                begin
                    t.s.level = '0;
                    t.s.mode  = M_LSTR_OPEN;
                    t = f_lstr_open(t, b);
                end
                else
                begin
                    t = f_enter(t, LV_FULL, b);
                end
            end
            M_CMT_OPEN:
            begin
                if (b == CH_LBR)
                begin
                    t.s.level = '0;
                    t.s.mode  = M_LCMT_OPEN;
                end
                else
                begin
                    t = f_line_cmt(t, b);
                end
            end
            M_LINE_CMT:     t = f_line_cmt(t, b);
            M_LCMT_OPEN:
            begin
                if (b == CH_EQ)
                begin
                    if (s0.level >= LVL_MAX)
                    begin
                        t = f_raise(t, ERR_LEVEL);
                    end
                    else
                    begin
                        t.s.level = s0.level + LVL_W'(1);
                    end
                end
                else if (b == CH_LBR)
                begin
                    t.s.cand    = 1'b0;
                    t.s.eq_seen = '0;
                    t.s.mode    = M_LCMT_BODY;
                end
                else
                begin
                    t = f_raise(t, ERR_COMMENT);
                end
            end
            M_LCMT_BODY:
            begin
                done = f_close_done(s0, b);
                t.s  = f_close_upd(s0, b);
                if (done)
                begin
                    t.s.mode = M_AFT_COMMENT;
                end
                else if (b == CH_LF)
                begin
                    t = f_emit(t, CH_LF);
                end
            end
            M_QSTR_ESC:
            begin
                if (b == s0.quote)
                begin
                    t = f_emit(t, b);
                    t.s.mode = M_QSTR;
                end
                else
                begin
                    t = f_quoted(t, b);
                end
            end
            M_QSTR:         t = f_quoted(t, b);
            M_LSTR_OPEN:    t = f_lstr_open(t, b);
            M_LSTR_BODY:
            begin
                t = f_emit(t, b);
                done = f_close_done(t.s, b);
                t.s  = f_close_upd(t.s, b);
                if (done)
                begin
                    t.s.mode = M_AFT_LONG;
                end
            end
            default:
            begin
                t = t;
            end
        endcase

        // End of script: release pending text, flag open constructs
        if (last)
        begin
            case (t.s.mode)
                M_PEND_DASH:    t = f_emit(t, CH_DASH);
                M_PEND_BRACKET: t = f_emit(t, CH_LBR);
                M_CMT_OPEN, M_LINE_CMT, M_LCMT_OPEN, M_LCMT_BODY:
                                t = f_raise(t, ERR_COMMENT);
                M_QSTR, M_QSTR_ESC, M_LSTR_OPEN, M_LSTR_BODY:
                                t = f_raise(t, ERR_STRING);
                default:        t = t;
            endcase
            if (t.s.mode != M_DRAIN && t.s.held_v)
            begin
                t = f_push(t, t.s.held, 1'b1, ERR_NONE);
            end
            t.s = STATE_RST;
        end

        if (t.n != 2'd0)
        begin
            t.r[t.n - 2'd1].run_last = 1'b1;
        end
        return t;
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic            in_full_reg, in_full_next;
    in_item_t        in_item_reg;
    scan_state_t     state_reg, state_next;
    logic [1:0]      res_cnt_reg, res_cnt_next;
    out_item_t [2:0] res_reg, res_next;

    logic  take;
    logic  pop;
    logic  buf_free;
    logic  adv;
    step_t step_c;

    // Handshake
    assign mini_valid   = (res_cnt_reg != 2'd0);
    assign mini_item    = res_reg[0];
    assign pop          = mini_valid && !mini_stall;
    assign buf_free     = (res_cnt_reg == 2'd0) || (res_cnt_reg == 2'd1 && pop);
    assign adv          = in_full_reg && buf_free;
    assign script_stall = in_full_reg && !buf_free;
    assign take         = script_valid && !script_stall;

    // Scan the registered byte
    assign step_c = f_step(state_reg, in_item_reg.in_byte, in_item_reg.in_last);

    // Next-state logic for input stage, scanner state and result buffer
    always_comb
    begin
        in_full_next = take || (in_full_reg && !adv);
        state_next   = state_reg;
        res_cnt_next = res_cnt_reg;
        res_next     = res_reg;
        if (adv)
        begin
            state_next   = step_c.s;
            res_cnt_next = step_c.n;
            res_next     = step_c.r;
        end
        else if (pop)
        begin
            res_next[0]  = res_reg[1];
            res_next[1]  = res_reg[2];
            res_cnt_next = res_cnt_reg - 2'd1;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
            state_reg   <= STATE_RST;
            res_cnt_reg <= 2'd0;
        end
        else
        begin
            in_full_reg <= in_full_next;
            state_reg   <= state_next;
            res_cnt_reg <= res_cnt_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_item_reg <= script_item;
        end
        res_reg <= res_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `LSMF_ASSERT_IMPL(a_err_is_final,
        mini_valid && mini_item.error_kind != ERR_NONE,
        mini_item.stream_end && mini_item.run_last && res_cnt_reg == 2'd1)
    `LSMF_ASSERT_IMPL(a_end_closes_run,
        mini_valid && mini_item.stream_end,
        mini_item.run_last)
    `LSMF_ASSERT_NEXT(a_last_resets,
        adv && in_item_reg.in_last,
        state_reg.mode == M_NORMAL && state_reg.line_st && !state_reg.held_v)
    `LSMF_ASSERT_NEXT(a_drain_silent,
        adv && state_reg.mode == M_DRAIN && !in_item_reg.in_last,
        res_cnt_reg == 2'd0)
    `LSMF_ASSERT_NEXT(a_pop_count,
        pop && !adv,
        res_cnt_reg == $past(res_cnt_reg) - 2'd1)

endmodule

`default_nettype wire

FILE: verif/lsmf_checker.sv
// ----------------------------------------------------------------------------
// Lua minify filter checker
// Watches both channels of the filter and predicts the minified byte stream
// from each accepted script byte. Checks every output transaction, field by
// field, against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsmf_checker #(
    parameter int MAX_LEVEL = lsmf_pkg::MAX_LEVEL_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                script_valid,
    input  wire logic                script_stall,
    input  wire lsmf_pkg::in_item_t  script_item,
    input  wire logic                mini_valid,
    input  wire logic                mini_stall,
    input  wire lsmf_pkg::out_item_t mini_item,
    output int                       fail_count,
    output int                       bytes_owed
);

    import lsmf_pkg::*;

    // Scanner state of the prediction
    scan_mode_t mode;
    int         level;
    int         close_eq;
    logic       close_cand;
    logic [7:0] quote_ch;
    logic [7:0] held;
    logic       held_ok;
    logic       line_head;

    // Transactions from the current byte, and all those still owed
    out_item_t  step_bytes[$];
    out_item_t  owed_q[$];

    function automatic void scanner_clear();
        mode       = M_NORMAL;
        level      = 0;
        close_eq   = 0;
        close_cand = 1'b0;
        quote_ch   = 8'h00;
        held       = 8'h00;
        held_ok    = 1'b0;
        line_head  = 1'b1;
    endfunction

    function automatic void put_result(logic [7:0] b, logic final_byte, err_kind_t kind);
        out_item_t r;
        r.out_byte   = b;
        r.run_last   = 1'b0;
        r.stream_end = final_byte;
        r.error_kind = kind;
        step_bytes.push_back(r);
    endfunction

    // One byte is held back so that the last one can carry stream_end
    function automatic void keep_byte(logic [7:0] b);
        if (held_ok)
            put_result(held, 1'b0, ERR_NONE);
        held    = b;
        held_ok = 1'b1;
    endfunction

    function automatic void abort_script(err_kind_t kind);
        held_ok = 1'b0;
        put_result(8'h00, 1'b1, kind);
        mode = M_DRAIN;
    endfunction

    // Fresh token; lvl says which of the checks it still goes through
    function automatic void start_token(entry_lvl_t lvl, logic [7:0] b);
        if (lvl <= LV_FULL && b == CH_DASH)
        begin
            mode = M_PEND_DASH;
            return;
        end
        if (lvl <= LV_QUOTE && (b == CH_SQUOTE || b == CH_DQUOTE))
        begin
            keep_byte(b);
            quote_ch = b;
            mode     = M_QSTR;
            return;
        end
        if (lvl <= LV_BRACKET && b == CH_LBR)
        begin
            mode = M_PEND_BRACKET;
            return;
        end
        mode = M_NORMAL;
        if (b == CH_CR)
            return;
        keep_byte(b);
        if (b == CH_LF)
            line_head = 1'b1;
    endfunction

    // Follows a closing bracket run; true once it matches the opener
    function automatic logic closer_done(logic [7:0] b);
        if (close_cand)
        begin
            if (b == CH_EQ && close_eq < level)
            begin
                close_eq = close_eq + 1;
                return 1'b0;
            end
            if (b == CH_RBR && close_eq == level)
            begin
                close_cand = 1'b0;
                return 1'b1;
            end
            close_cand = 1'b0;
        end
        if (b == CH_RBR)
        begin
            close_cand = 1'b1;
            close_eq   = 0;
        end
        return 1'b0;
    endfunction

    function automatic void line_comment_step(logic [7:0] b);
        if (b == CH_LF)
        begin
            keep_byte(CH_LF);
            line_head = 1'b1;
            mode      = M_NORMAL;
        end
        else
            mode = M_LINE_CMT;
    endfunction

    function automatic void quoted_step(logic [7:0] b);
        keep_byte(b);
        if (b == quote_ch)
            mode = M_AFT_QUOTE;
        else if (b == CH_BSLASH)
            mode = M_QSTR_ESC;
        else
            mode = M_QSTR;
    endfunction

    function automatic void long_open_step(logic [7:0] b);
        if (b == CH_EQ)
        begin
            if (level >= MAX_LEVEL)
            begin
                abort_script(ERR_LEVEL);
                return;
            end
            level = level + 1;
            keep_byte(b);
        end
        else if (b == CH_LBR)
        begin
            keep_byte(b);
            close_cand = 1'b0;
            close_eq   = 0;
            mode       = M_LSTR_BODY;
        end
        else
            abort_script(ERR_STRING);
    endfunction

    // Predict the output transactions caused by one script byte
    function automatic void minify_step(in_item_t it);
        logic [7:0] b;
        out_item_t  r;
        b = it.in_byte;
        step_bytes.delete();
        case (mode)
            M_NORMAL:
                if (!(line_head && (b == CH_SPACE || b == CH_TAB || b == CH_CR)))
                begin
                    line_head = 1'b0;
                    start_token(LV_FULL, b);
                end
            M_AFT_COMMENT: start_token(LV_QUOTE, b);
            M_AFT_QUOTE:   start_token(LV_BRACKET, b);
            M_AFT_LONG:    start_token(LV_PLAIN, b);
            M_PEND_DASH:
                if (b == CH_DASH)
                    mode = M_CMT_OPEN;
                else
                begin
                    keep_byte(CH_DASH);
                    start_token(LV_FULL, b);
                end
            M_PEND_BRACKET:
            begin
                keep_byte(CH_LBR);
                if (b == CH_EQ || b == CH_LBR)
                begin
                    level = 0;
                    mode  = M_LSTR_OPEN;
                    long_open_step(b);
                end
                else
                    start_token(LV_FULL, b);
            end
            M_CMT_OPEN:
                if (b == CH_LBR)
                begin
                    level = 0;
                    mode  = M_LCMT_OPEN;
                end
                else
                    line_comment_step(b);
            M_LINE_CMT: line_comment_step(b);
            M_LCMT_OPEN:
                if (b == CH_EQ)
                begin
                    if (level >= MAX_LEVEL)
                        abort_script(ERR_LEVEL);
                    else
                        level = level + 1;
                end
                else if (b == CH_LBR)
                begin
                    close_cand = 1'b0;
                    close_eq   = 0;
                    mode       = M_LCMT_BODY;
                end
                else
                    abort_script(ERR_COMMENT);
            M_LCMT_BODY:
                if (closer_done(b))
                    mode = M_AFT_COMMENT;
                else if (b == CH_LF)
                    keep_byte(CH_LF);
            M_QSTR_ESC:
                if (b == quote_ch)
                begin
                    keep_byte(b);
                    mode = M_QSTR;
                end
                else
                    quoted_step(b);
            M_QSTR:      quoted_step(b);
            M_LSTR_OPEN: long_open_step(b);
            M_LSTR_BODY:
            begin
                keep_byte(b);
                if (closer_done(b))
                    mode = M_AFT_LONG;
            end
            default: ;
        endcase

        // End of script: release pending text or flag what was left open
        if (it.in_last)
        begin
            case (mode)
                M_PEND_DASH:    keep_byte(CH_DASH);
                M_PEND_BRACKET: keep_byte(CH_LBR);
                M_CMT_OPEN, M_LINE_CMT, M_LCMT_OPEN, M_LCMT_BODY:
                    abort_script(ERR_COMMENT);
                M_QSTR, M_QSTR_ESC, M_LSTR_OPEN, M_LSTR_BODY:
                    abort_script(ERR_STRING);
                default: ;
            endcase
            if (mode != M_DRAIN && held_ok)
                put_result(held, 1'b1, ERR_NONE);
            scanner_clear();
        end

        if (step_bytes.size() > 0)
        begin
            r = step_bytes.pop_back();
            r.run_last = 1'b1;
            step_bytes.push_back(r);
        end
        foreach (step_bytes[i])
            owed_q.push_back(step_bytes[i]);
    endfunction

    // Predict on each accepted script byte, compare each accepted output
    always @(posedge clk or negedge rst_n)
    begin : watch
        out_item_t want;
        if (!rst_n)
        begin
            scanner_clear();
            owed_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (script_valid && !script_stall)
                minify_step(script_item);
            if (mini_valid && !mini_stall)
            begin
                if (owed_q.size() == 0)
                begin
                    $error("mini_item: transaction with none expected, out_byte %02h",
                           mini_item.out_byte);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want = owed_q.pop_front();
                    if (mini_item.out_byte !== want.out_byte)
                    begin
                        $error("out_byte: expected %02h, got %02h",
                               want.out_byte, mini_item.out_byte);
                        fail_count = fail_count + 1;
                    end
                    if (mini_item.run_last !== want.run_last)
                    begin
                        $error("run_last: expected %0d, got %0d",
                               want.run_last, mini_item.run_last);
                        fail_count = fail_count + 1;
                    end
                    if (mini_item.stream_end !== want.stream_end)
                    begin
                        $error("stream_end: expected %0d, got %0d",
                               want.stream_end, mini_item.stream_end);
                        fail_count = fail_count + 1;
                    end
                    if (mini_item.error_kind !== want.error_kind)
                    begin
                        $error("error_kind: expected %0d, got %0d",
                               want.error_kind, mini_item.error_kind);
                        fail_count = fail_count + 1;
                    end
                end
            end
        end
        bytes_owed = owed_q.size();
    end

endmodule

FILE: verif/tb_lua_source_minify_filter.sv
// ----------------------------------------------------------------------------
// Lua minify filter testbench
// Feeds Lua scripts byte by byte: a few short directed scripts for the corner
// cases, then random scripts built from comments, strings, long brackets,
// indentation and noise, with broken endings mixed in. Both channels idle at
// random; the checker beside the filter does all prediction and comparison.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_lua_source_minify_filter;

    import lsmf_pkg::*;

    localparam int RANDOM_BYTES = 280;
    localparam int CYCLE_LIMIT  = 300000;

    logic      clk;
    logic      rst_n;
    logic      script_valid;
    logic      script_stall;
    in_item_t  script_item;
    logic      mini_valid;
    logic      mini_stall;
    out_item_t mini_item;

    int        fail_count;
    int        bytes_owed;
    int        cycle_count = 0;
    logic      calm;

    // Script under construction and the count of its drained tail bytes
    logic [7:0] script_buf[$];
    int         ignored_n;

    lua_source_minify_filter #(
        .MAX_LEVEL (MAX_LEVEL_DEF)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .script_valid (script_valid),
        .script_stall (script_stall),
        .script_item  (script_item),
        .mini_valid   (mini_valid),
        .mini_stall   (mini_stall),
        .mini_item    (mini_item)
    );

    lsmf_checker #(
        .MAX_LEVEL (MAX_LEVEL_DEF)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .script_valid (script_valid),
        .script_stall (script_stall),
        .script_item  (script_item),
        .mini_valid   (mini_valid),
        .mini_stall   (mini_stall),
        .mini_item    (mini_item),
        .fail_count   (fail_count),
        .bytes_owed   (bytes_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm)
            return 0;
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Output side back-pressure
    initial
    begin : sink_stall
        int n;
        mini_stall <= 1'b0;
        forever
        begin
            n = pick_gap();
            if (n > 0)
            begin
                mini_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            mini_stall <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // Ordinary text; apart from the space, dropped at a line start, no character the scanner reacts to
    function automatic logic [7:0] plain_char();
        string pool;
        pool = "abcxyz019_(),.+*~ #";
        return pool[$urandom_range(0, pool.len() - 1)];
    endfunction

    function automatic logic [7:0] special_char();
        case ($urandom_range(0, 8))
            0:       return CH_DASH;
            1:       return CH_LBR;
            2:       return CH_RBR;
            3:       return CH_EQ;
            4:       return CH_SQUOTE;
            5:       return CH_DQUOTE;
            6:       return CH_BSLASH;
            7:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    function automatic int pick_level();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(0, 2);
        return $urandom_range(3, MAX_LEVEL_DEF);
    endfunction

    function automatic void add_run(logic [7:0] b, int n);
        int i;
        for (i = 0; i < n; i++)
            script_buf.push_back(b);
    endfunction

    function automatic void add_plain(int n);
        int i;
        for (i = 0; i < n; i++)
            script_buf.push_back(plain_char());
    endfunction

    // Body of a long bracket, with near-miss closers now and then
    function automatic void add_long_body(int k);
        int i;
        int n;
        n = $urandom_range(0, 8);
        for (i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 9))
                0: script_buf.push_back(CH_LF);
                1: script_buf.push_back(special_char());
                2:
                begin
                    script_buf.push_back(CH_RBR);
                    add_run(CH_EQ, (k > 0 && $urandom_range(0, 1)) ? k - 1 : k + 1);
                    script_buf.push_back(CH_RBR);
                end
                default: script_buf.push_back(plain_char());
            endcase
        end
    endfunction

    // Long comment or long string; left open when closed is low
    function automatic void add_long(logic comment, int k, logic closed);
        if (comment)
            add_run(CH_DASH, 2);
        script_buf.push_back(CH_LBR);
        add_run(CH_EQ, k);
        script_buf.push_back(CH_LBR);
        add_long_body(k);
        if (closed)
        begin
            script_buf.push_back(CH_RBR);
            add_run(CH_EQ, k);
            script_buf.push_back(CH_RBR);
        end
    endfunction

    function automatic void add_quoted(logic closed);
        logic [7:0] q;
        int         i;
        int         n;
        q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
        script_buf.push_back(q);
        n = $urandom_range(0, 6);
        for (i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 5))
                0:
                begin
                    script_buf.push_back(CH_BSLASH);
                    script_buf.push_back(q);
                end
                1: script_buf.push_back(CH_BSLASH);
                2: script_buf.push_back(q == CH_SQUOTE ? CH_DQUOTE : CH_SQUOTE);
                3: script_buf.push_back(CH_LF);
                default: script_buf.push_back(plain_char());
            endcase
        end
        // A trailing backslash would swallow the closing quote
        if (script_buf[script_buf.size() - 1] == CH_BSLASH)
            script_buf.push_back(plain_char());
        if (closed)
            script_buf.push_back(q);
    endfunction

    function automatic void add_token();
        int r;
        int i;
        r = $urandom_range(0, 99);
        if (r < 18)
            add_plain($urandom_range(1, 5));
        else if (r < 28)
        begin
            script_buf.push_back(CH_LF);
            for (i = $urandom_range(0, 3); i > 0; i--)
                case ($urandom_range(0, 2))
                    0:       script_buf.push_back(CH_SPACE);
                    1:       script_buf.push_back(CH_TAB);
                    default: script_buf.push_back(CH_CR);
                endcase
        end
        else if (r < 32)
            script_buf.push_back(CH_CR);
        else if (r < 42)
        begin
            add_run(CH_DASH, 2);
            add_plain($urandom_range(0, 6));
            script_buf.push_back(CH_LF);
        end
        else if (r < 52)
            add_long(1'b1, pick_level(), 1'b1);
        else if (r < 64)
            add_quoted(1'b1);
        else if (r < 74)
            add_long(1'b0, pick_level(), 1'b1);
        else if (r < 80)
        begin
            script_buf.push_back($urandom_range(0, 1) ? CH_DASH : CH_LBR);
            script_buf.push_back(plain_char());
        end
        else if (r < 86)
            script_buf.push_back(8'($urandom_range(0, 255)));
        else if (r < 90)
            case ($urandom_range(0, 3))
                0:       script_buf.push_back(8'h00);
                1:       script_buf.push_back(8'hFF);
                2:       script_buf.push_back(8'h80);
                default: script_buf.push_back(8'h7F);
            endcase
        else
            script_buf.push_back(special_char());
    endfunction

    // Bytes after an error are swallowed by the filter
    function automatic void add_tail();
        int i;
        ignored_n = $urandom_range(0, 3);
        for (i = 0; i < ignored_n; i++)
            script_buf.push_back(8'($urandom_range(0, 255)));
    endfunction

    // Malformed endings, one kind per call
    function automatic void add_broken(int kind);
        case (kind)
            0:
            begin
                // dash dash bracket without a long opener
                add_run(CH_DASH, 2);
                script_buf.push_back(CH_LBR);
                add_run(CH_EQ, $urandom_range(0, 2));
                script_buf.push_back(plain_char());
                add_tail();
            end
            1:
            begin
                // bracket and equals without the second bracket
                script_buf.push_back(CH_LBR);
                add_run(CH_EQ, $urandom_range(1, 3));
                script_buf.push_back(plain_char());
                add_tail();
            end
            2:
            begin
                // one equals sign more than the deepest level
                if ($urandom_range(0, 1))
                    add_run(CH_DASH, 2);
                script_buf.push_back(CH_LBR);
                add_run(CH_EQ, MAX_LEVEL_DEF + 1);
                add_tail();
            end
            3:
                // script ends inside a string
                if ($urandom_range(0, 1))
                    add_quoted(1'b0);
                else
                    add_long(1'b0, $urandom_range(0, 2), 1'b0);
            default:
                // script ends inside a comment
                case ($urandom_range(0, 2))
                    0:
                    begin
                        add_run(CH_DASH, 2);
                        add_plain($urandom_range(0, 4));
                    end
                    1: add_long(1'b1, $urandom_range(0, 2), 1'b0);
                    default:
                    begin
                        add_run(CH_DASH, 2);
                        script_buf.push_back(CH_LBR);
                        add_run(CH_EQ, $urandom_range(0, 3));
                    end
                endcase
        endcase
    endfunction

    function automatic void build_script(int script_no);
        int i;
        script_buf.delete();
        ignored_n = 0;
        for (i = $urandom_range(1, 7); i > 0; i--)
            add_token();
        if (script_no % 3 == 2)
            add_broken((script_no / 3) % 5);
    endfunction

    // One script byte per transaction, with a random gap before it
    task automatic send_byte(input logic [7:0] b, input logic last_flag);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            script_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        script_valid <= 1'b1;
        script_item  <= '{in_byte: b, in_last: last_flag};
        @(posedge clk);
        while (script_stall)
            @(posedge clk);
    endtask

    task automatic send_script();
        int i;
        for (i = 0; i < script_buf.size(); i++)
            send_byte(script_buf[i], i == script_buf.size() - 1);
    endtask

    initial
    begin : stimulus
        int script_no;
        int fed;
        calm = 1'b0;
        rst_n        <= 1'b0;
        script_valid <= 1'b0;
        script_item  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Indentation, stray carriage returns, byte extremes, lone dash at the end
        script_buf = '{CH_SPACE, CH_TAB, CH_CR, 8'h00, CH_CR, 8'hFF, CH_LF, CH_SPACE, CH_DASH};
        send_script();
        // Comment opener without a long bracket, then a drained byte
        script_buf = '{CH_DASH, CH_DASH, CH_LBR, 8'h78, 8'h79};
        send_script();
        // Long string opener that never gets its second bracket
        script_buf = '{CH_LBR, CH_EQ, 8'h78};
        send_script();
        // Backslash does not escape a backslash; string left open at the end
        script_buf = '{CH_SQUOTE, CH_BSLASH, CH_SQUOTE, CH_BSLASH, CH_BSLASH, CH_SQUOTE};
        send_script();
        // Lone bracket as the whole script
        script_buf = '{CH_LBR};
        send_script();
        // Script ends inside a line comment
        script_buf = '{CH_DASH, CH_DASH, 8'h78};
        send_script();

        // Random scripts; every fourth one runs without idling
        script_no = 0;
        fed       = 0;
        while (fed < RANDOM_BYTES)
        begin
            calm = (script_no % 4 == 3);
            build_script(script_no);
            fed = fed + script_buf.size() - ignored_n;
            send_script();
            script_no = script_no + 1;
        end
        script_valid <= 1'b0;
        calm = 1'b0;

        // Drain what is still owed, then allow for the pipeline
        @(posedge clk);
        while (bytes_owed != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
